### rtl/frs_pkg.sv
// Shared widths and constants for the windowed frame-rate statistics block.
`default_nettype none
package frs_pkg;
  localparam int TIME_W = 24;
  localparam int RATE_W = 28;
  localparam int FILL_W = 8;
  localparam logic [RATE_W-1:0] RATE_NUM = 28'd256000000;
  localparam logic [RATE_W-1:0] RATE_CAP = 28'd256000000;

  // Which rate the shared divider is working on
  typedef enum logic [1:0] {
    SEL_MIN  = 2'd0,
    SEL_MAX  = 2'd1,
    SEL_MEAN = 2'd2
  } rate_sel_t;
endpackage
`default_nettype wire

### rtl/windowed_frame_rate_stats_core.sv
// Top level: sample chain, window scan and three serial rate divisions.
// An accepted item is scanned over the whole chain (S_SCAN); the shared divider then
//   runs the min, max and mean divisions in turn (S_DIV), with NUM_W = clog2(HISTORY+1)+28.
// S_OUT loads the result; the input stalls from accept until then, so one item is in
//   flight at a time and the chain scan and the shared divider set the pace.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, rst_n low) empties the window and clears all control state.
`default_nettype none
module windowed_frame_rate_stats_core import frs_pkg::*; #(
  parameter int HISTORY = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [TIME_W-1:0] in_frame_time_us,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [RATE_W-1:0] out_min_rate,
  output logic      [RATE_W-1:0] out_max_rate,
  output logic      [RATE_W-1:0] out_mean_rate,
  output logic      [FILL_W-1:0] out_window_fill
);
  localparam int CNT_W = $clog2(HISTORY + 1);
  localparam int IDX_W = $clog2(HISTORY);
  localparam int SUM_W = TIME_W + CNT_W;
  localparam int NUM_W = CNT_W + RATE_W;
  localparam logic [CNT_W:0] HIST_C = (CNT_W+1)'(HISTORY);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIV, S_OUT} state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  fill_r;
  logic [IDX_W-1:0]  step_r;
  logic [TIME_W-1:0] lo_r, hi_r;
  logic [SUM_W-1:0]  sum_r;
  logic [NUM_W-1:0]  mean_num_r;
  rate_sel_t         sel_r;
  logic              start_r;
  logic [RATE_W-1:0] min_q_r, max_q_r, mean_q_r;
  logic              out_valid_r;
  logic [RATE_W-1:0] out_min_r, out_max_r, out_mean_r;
  logic [FILL_W-1:0] out_fill_r;

  logic              in_acc, scanning, chain_en, in_win, div_done;
  logic [TIME_W-1:0] cell_q [HISTORY];
  logic [TIME_W-1:0] tail;
  logic [NUM_W-1:0]  div_num;
  logic [SUM_W-1:0]  div_den;
  logic [RATE_W-1:0] div_quo;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign scanning = (state_r == S_SCAN);
  assign chain_en = in_acc || scanning;
  assign tail     = cell_q[HISTORY-1];

  // Sample chain: a new item shifts in at the head; during the scan the chain rotates
  genvar gi;
  for (gi = 0; gi < HISTORY; gi++) begin : g_cell
    logic [TIME_W-1:0] d;
    if (gi == 0) begin : g_head
      assign d = in_acc ? in_frame_time_us : tail;
    end else begin : g_body
      assign d = cell_q[gi-1];
    end
    frs_cell u_cell (.clk(clk), .en(chain_en), .d(d), .q(cell_q[gi]));
  end

  // tail shows cell HISTORY-1-step; it holds a sample when step >= HISTORY-fill
  assign in_win = ((CNT_W+1)'(step_r) + (CNT_W+1)'(fill_r)) >= HIST_C;

  // divider operands
  always_comb begin
    div_num = NUM_W'(RATE_NUM);
    div_den = SUM_W'(hi_r);
    case (sel_r)
      SEL_MAX: div_den = SUM_W'(lo_r);
      SEL_MEAN: begin
        div_num = mean_num_r;
        div_den = sum_r;
      end
      default: ;
    endcase
  end

  frs_div #(.NUM_W(NUM_W), .DEN_W(SUM_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(start_r),
    .num(div_num), .den(div_den), .done(div_done), .quo(div_quo)
  );

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      step_r      <= '0;
      sel_r       <= SEL_MIN;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      // result taken and no new one loaded this cycle
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (fill_r != CNT_W'(HISTORY)) begin
              fill_r <= fill_r + 1'b1;
            end
            step_r  <= '0;
            lo_r    <= '1;
            hi_r    <= '0;
            sum_r   <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (in_win) begin
            if (tail < lo_r) lo_r <= tail;
            if (tail > hi_r) hi_r <= tail;
            sum_r <= sum_r + SUM_W'(tail);
          end
          mean_num_r <= NUM_W'(fill_r) * NUM_W'(RATE_NUM);
          step_r     <= step_r + 1'b1;
          if (step_r == IDX_W'(HISTORY - 1)) begin
            sel_r   <= SEL_MIN;
            start_r <= 1'b1;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (sel_r)
              SEL_MIN: begin
                min_q_r <= div_quo;
                sel_r   <= SEL_MAX;
                start_r <= 1'b1;
              end
              SEL_MAX: begin
                max_q_r <= div_quo;
                sel_r   <= SEL_MEAN;
                start_r <= 1'b1;
              end
              default: begin
                mean_q_r <= div_quo;
                state_r  <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_min_r   <= min_q_r;
            out_max_r   <= max_q_r;
            out_mean_r  <= mean_q_r;
            out_fill_r  <= FILL_W'(fill_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_min_rate    = out_min_r;
  assign out_max_rate    = out_max_r;
  assign out_mean_rate   = out_mean_r;
  assign out_window_fill = out_fill_r;

`ifndef SYNTH
  // an accepted item always starts a window scan
  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_SCAN) else $error("accept did not start scan");
  // the window never holds more than HISTORY samples
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(HISTORY)) else $error("fill count overflow");
  // a new result only appears once the window holds a sample
  a_res_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> fill_r != '0) else $error("result from empty window");
`endif
endmodule
`default_nettype wire

### rtl/frs_cell.sv
// One cell of the sample chain: holds one frame time, takes its neighbour's value.
`default_nettype none
module frs_cell import frs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [TIME_W-1:0] d,
  output logic      [TIME_W-1:0] q
);
  logic [TIME_W-1:0] q_r;

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire

### rtl/frs_div.sv
// Restoring divider, one quotient bit per cycle, result floored and saturated.
`default_nettype none
module frs_div import frs_pkg::*; #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic     [RATE_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, done_r, zero_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r, quo_r;
  logic [DEN_W-1:0] den_r, rem_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign qbit  = (trial >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      zero_r <= (den == '0);
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      num_r <= num_r << 1;
      rem_r <= qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 :
                (quo_r > NUM_W'(RATE_CAP)) ? RATE_CAP : quo_r[RATE_W-1:0];
endmodule
`default_nettype wire
